>>> src/ste_pkg.sv
// Shared types, constants and the sine table of the sine tone generator.
// Used by every other file of the block; depends on nothing.
package ste_pkg;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_START   = 2'd1,
    KIND_STOP    = 2'd2,
    KIND_MS_TICK = 2'd3
  } kind_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  localparam int unsigned FREQ_W        = 16;
  localparam int unsigned DUR_W         = 32;
  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned VOLUME_W      = 8;
  localparam logic [7:0]  VOLUME_RESET  = 8'd200;
  localparam int unsigned QUEUE_DEPTH   = 4;

  // The increment is the frequency times 2^PHASE_BITS over the output rate,
  // formed as a product with a reciprocal carrying INC_FRAC_BITS extra
  // fraction bits.
  localparam int unsigned INC_FRAC_BITS = 33;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned INDEX_BITS    = 8;
  localparam int unsigned MAG_W         = 15;
  localparam int unsigned LEVEL_IN_W    = MAG_W + VOLUME_W;

  // 24000 / (255 * 32768) reduces to 25 / 8704.
  localparam logic [63:0] LEVEL_NUM     = 64'd25;
  localparam logic [63:0] LEVEL_DEN     = 64'd8704;
  localparam int unsigned LEVEL_SHIFT   = 37;
  localparam int unsigned LEVEL_MUL_W   = 29;
  localparam logic [63:0] LEVEL_MUL_FULL =
    (((64'd1 << LEVEL_SHIFT) * LEVEL_NUM) + LEVEL_DEN - 64'd1) / LEVEL_DEN;
  localparam logic [LEVEL_MUL_W-1:0] LEVEL_MUL = LEVEL_MUL_FULL[LEVEL_MUL_W-1:0];
  localparam int unsigned LEVEL_PROD_W  = LEVEL_IN_W + LEVEL_MUL_W;

  localparam logic [63:0] HALF_PI_Q60   = 64'h1921FB54442D1847;

  typedef logic signed [SAMPLE_W-1:0] sine_rom_t [TABLE_ENTRIES];

  function automatic int unsigned inc_mul_width(int unsigned acc_bits,
                                                int unsigned rate_hz);
    return acc_bits + INC_FRAC_BITS + 2 - $clog2(rate_hz);
  endfunction

  function automatic int unsigned entry_width(int unsigned mul_w);
    return mul_w + 2 * FREQ_W + 1 + DUR_W + 2;
  endfunction

  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [63:0] al, ah, bl, bh, lo, m1, m2, hi, mid, low, high;
    al   = {32'h0, a[31:0]};
    ah   = {32'h0, a[63:32]};
    bl   = {32'h0, b[31:0]};
    bh   = {32'h0, b[63:32]};
    lo   = al * bl;
    m1   = ah * bl;
    m2   = al * bh;
    hi   = ah * bh;
    mid  = (lo >> 32) + {32'h0, m1[31:0]} + {32'h0, m2[31:0]};
    low  = {32'h0, lo[31:0]} | (mid << 32);
    high = hi + (m1 >> 32) + (m2 >> 32) + (mid >> 32);
    return (high << 4) | (low >> 60);
  endfunction

  function automatic logic [63:0] sin_q60(logic [63:0] x);
    logic [63:0] x2, term, sum;
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    term = mul_q60(term, x2) / 64'd6;   sum = sum - term;
    term = mul_q60(term, x2) / 64'd20;  sum = sum + term;
    term = mul_q60(term, x2) / 64'd42;  sum = sum - term;
    term = mul_q60(term, x2) / 64'd72;  sum = sum + term;
    term = mul_q60(term, x2) / 64'd110; sum = sum - term;
    term = mul_q60(term, x2) / 64'd156; sum = sum + term;
    term = mul_q60(term, x2) / 64'd210; sum = sum - term;
    term = mul_q60(term, x2) / 64'd272; sum = sum + term;
    term = mul_q60(term, x2) / 64'd342; sum = sum - term;
    term = mul_q60(term, x2) / 64'd420; sum = sum + term;
    term = mul_q60(term, x2) / 64'd506; sum = sum - term;
    term = mul_q60(term, x2) / 64'd600; sum = sum + term;
    term = mul_q60(term, x2) / 64'd702; sum = sum - term;
    return sum;
  endfunction

  function automatic sine_rom_t build_rom();
    sine_rom_t   rom;
    logic [63:0] u, quad, rem, x, s, q;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      u    = 64'(4 * i);
      quad = u / TABLE_ENTRIES;
      rem  = u % TABLE_ENTRIES;
      if (quad[0]) begin
        rem = 64'(TABLE_ENTRIES) - rem;
      end
      x = (HALF_PI_Q60 / TABLE_ENTRIES) * rem
        + ((HALF_PI_Q60 % TABLE_ENTRIES) * rem) / TABLE_ENTRIES;
      s = sin_q60(x);
      q = (s + (64'd1 << 44)) >> 45;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      rom[i] = (quad >= 64'd2) ? -signed'(q[15:0]) : signed'(q[15:0]);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_rom();

endpackage

>>> src/ste_if.sv
// Request channel and sample channel of the sine tone generator.
// Depends on ste_pkg for the field widths.
interface ste_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  kind;
  logic [ste_pkg::FREQ_W-1:0]  frequency;
  logic [ste_pkg::DUR_W-1:0]   duration_ms;

  modport source (output valid, output kind, output frequency, output duration_ms,
                  input ready);
  modport sink   (input valid, input kind, input frequency, input duration_ms,
                  output ready);
endinterface

interface ste_smp_if;
  logic                                valid;
  logic                                ready;
  logic signed [ste_pkg::SAMPLE_W-1:0] sample;
  logic                                tone_on;

  modport source (output valid, output sample, output tone_on, input ready);
  modport sink   (input valid, input sample, input tone_on, output ready);
endinterface

>>> src/sine_tone_generator.sv
// Top level of the sine tone generator: front end, request queue, back end.
// Depends on ste_pkg, ste_if, ste_front, ste_queue and ste_back.
//
//   Channel   Role     Moves                                   Handshake
//   cmd       sink     kind, frequency, duration_ms            valid / ready
//   result    source   sample, tone_on                         valid / ready
//   cfg       write    volume (8 bits)                         cfg_we
//
// One request is accepted per cycle; the front end stalls only when the
// four-entry request queue is full.
// A sample request passes the queue, the s1 register and the output register in
// that order; the back end retires one request per cycle while it is not stalled.
// The back end stalls only when both sample registers are full and the sink
// holds the result off.
// Reset is synchronous; volume returns to 200.
module sine_tone_generator #(
  parameter int unsigned PHASE_BITS  = 32,
  parameter int unsigned SAMPLE_RATE = 16000
) (
  input  logic                         clk,
  input  logic                         rst,
  ste_cmd_if.sink                      cmd,
  input  logic                         cfg_we,
  input  logic [ste_pkg::VOLUME_W-1:0] cfg_wdata,
  ste_smp_if.source                    result
);

  localparam int unsigned MUL_W   = ste_pkg::inc_mul_width(PHASE_BITS, SAMPLE_RATE);
  localparam int unsigned ENTRY_W = ste_pkg::entry_width(MUL_W);

  ste_pkg::q_status_t q_status;
  logic               push;
  logic               pop;
  logic [ENTRY_W-1:0] push_data;
  logic [ENTRY_W-1:0] pop_data;

  ste_front #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_front (
    .cmd       (cmd),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  ste_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (ste_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  ste_back #(
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_RATE (SAMPLE_RATE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pop_data  (pop_data),
    .q_status  (q_status),
    .pop       (pop),
    .result    (result)
  );

endmodule

>>> src/ste_front.sv
// Front end: accepts requests, classifies them and forms the partial
// products of the phase increment. Depends on ste_pkg and ste_if.
module ste_front #(
  parameter int unsigned PHASE_BITS  = 32,
  parameter int unsigned SAMPLE_RATE = 16000
) (
  ste_cmd_if.sink                   cmd,
  input  ste_pkg::q_status_t        q_status,
  output logic                      push,
  output logic [ste_pkg::entry_width(
    ste_pkg::inc_mul_width(PHASE_BITS, SAMPLE_RATE))-1:0] push_data
);

  localparam int unsigned MUL_W = ste_pkg::inc_mul_width(PHASE_BITS, SAMPLE_RATE);
  localparam int unsigned HALF  = MUL_W / 2;
  localparam int unsigned LO_W  = ste_pkg::FREQ_W + HALF;
  localparam int unsigned HI_W  = ste_pkg::FREQ_W + MUL_W - HALF;
  localparam logic [127:0] INC_NUM = 128'd1 << (PHASE_BITS + ste_pkg::INC_FRAC_BITS);
  localparam logic [127:0] INC_MUL_FULL =
    (INC_NUM + 128'(SAMPLE_RATE) - 128'd1) / 128'(SAMPLE_RATE);
  localparam logic [MUL_W-1:0] INC_MUL = INC_MUL_FULL[MUL_W-1:0];

  ste_pkg::kind_t  kind;
  logic [LO_W-1:0] pp_lo;
  logic [HI_W-1:0] pp_hi;
  logic            freq_nonzero;

  assign kind         = ste_pkg::kind_t'(cmd.kind);
  assign freq_nonzero = (cmd.frequency != '0);
  assign pp_lo = LO_W'(cmd.frequency) * LO_W'(INC_MUL[HALF-1:0]);
  assign pp_hi = HI_W'(cmd.frequency) * HI_W'(INC_MUL[MUL_W-1:HALF]);

  assign cmd.ready = !q_status.full;
  assign push      = cmd.valid && !q_status.full;
  assign push_data = {pp_hi, pp_lo, freq_nonzero, cmd.duration_ms, kind};

endmodule

>>> src/ste_queue.sv
// Short first-in first-out queue between the front end and the back end.
// Depends on ste_pkg for the status type.
module ste_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   push_data,
  input  logic               pop,
  output logic [WIDTH-1:0]   pop_data,
  output ste_pkg::q_status_t status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> src/ste_back.sv
// Back end: tone state, phase accumulator, table lookup, level scaling and
// the sample output register. Depends on ste_pkg and ste_if.
module ste_back #(
  parameter int unsigned PHASE_BITS  = 32,
  parameter int unsigned SAMPLE_RATE = 16000
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ste_pkg::VOLUME_W-1:0]    cfg_wdata,
  input  logic [ste_pkg::entry_width(
    ste_pkg::inc_mul_width(PHASE_BITS, SAMPLE_RATE))-1:0] pop_data,
  input  ste_pkg::q_status_t              q_status,
  output logic                            pop,
  ste_smp_if.source                       result
);

  localparam int unsigned MUL_W = ste_pkg::inc_mul_width(PHASE_BITS, SAMPLE_RATE);
  localparam int unsigned HALF  = MUL_W / 2;
  localparam int unsigned LO_W  = ste_pkg::FREQ_W + HALF;
  localparam int unsigned HI_W  = ste_pkg::FREQ_W + MUL_W - HALF;
  localparam int unsigned SUM_W = ste_pkg::FREQ_W + MUL_W;
  localparam int unsigned DUR_W = ste_pkg::DUR_W;

  ste_pkg::kind_t     q_kind;
  logic [DUR_W-1:0]   q_dur;
  logic               q_fnz;
  logic [LO_W-1:0]    q_pp_lo;
  logic [HI_W-1:0]    q_pp_hi;
  logic [SUM_W-1:0]   inc_sum;

  logic [ste_pkg::VOLUME_W-1:0] volume;
  logic [PHASE_BITS-1:0] phase, phase_next;
  logic [PHASE_BITS-1:0] tone_inc, tone_inc_next;
  logic [DUR_W-1:0]      ms_remaining, ms_remaining_next;
  logic [DUR_W-1:0]      ms_dec;
  logic                  tone_active, tone_active_next;
  logic                  limited_length, limited_length_next;
  logic                  freq_nonzero, freq_nonzero_next;

  logic [ste_pkg::INDEX_BITS-1:0]      rom_idx;
  logic signed [ste_pkg::SAMPLE_W-1:0] rom_word;
  logic                                rom_neg;
  logic [ste_pkg::MAG_W-1:0]           rom_mag;

  logic                                s1_valid;
  logic [ste_pkg::LEVEL_IN_W-1:0]      s1_level, s1_level_next;
  logic                                s1_neg, s1_neg_next;
  logic                                s1_tone_on;
  logic                                s1_free;
  logic                                out_free;

  logic [ste_pkg::LEVEL_PROD_W-1:0]    level_prod;
  logic signed [ste_pkg::SAMPLE_W-1:0] level_mag;

  logic                                out_valid;
  logic signed [ste_pkg::SAMPLE_W-1:0] out_sample;
  logic                                out_tone_on;

  assign {q_pp_hi, q_pp_lo, q_fnz, q_dur} = pop_data[$bits(pop_data)-1:2];
  assign q_kind  = ste_pkg::kind_t'(pop_data[1:0]);
  assign inc_sum = (SUM_W'(q_pp_hi) << HALF) + SUM_W'(q_pp_lo);

  assign out_free = !out_valid || result.ready;
  assign s1_free  = !s1_valid || out_free;
  assign pop      = !q_status.empty && s1_free;

  assign rom_idx  = phase[PHASE_BITS-1 -: ste_pkg::INDEX_BITS];
  assign rom_word = ste_pkg::SINE_ROM[rom_idx];
  assign rom_neg  = rom_word[ste_pkg::SAMPLE_W-1];
  assign rom_mag  = rom_neg ? ste_pkg::MAG_W'(-rom_word)
                            : rom_word[ste_pkg::MAG_W-1:0];
  assign ms_dec   = ms_remaining - DUR_W'(ms_remaining != '0);

  always_comb begin
    phase_next          = phase;
    tone_inc_next       = tone_inc;
    ms_remaining_next   = ms_remaining;
    tone_active_next    = tone_active;
    limited_length_next = limited_length;
    freq_nonzero_next   = freq_nonzero;
    s1_level_next       = '0;
    s1_neg_next         = 1'b0;
    if (pop) begin
      case (q_kind)
        ste_pkg::KIND_START: begin
          tone_inc_next       = inc_sum[ste_pkg::INC_FRAC_BITS +: PHASE_BITS];
          freq_nonzero_next   = q_fnz;
          ms_remaining_next   = q_dur;
          limited_length_next = (q_dur != '0);
          tone_active_next    = 1'b1;
        end
        ste_pkg::KIND_STOP: begin
          tone_active_next = 1'b0;
        end
        ste_pkg::KIND_MS_TICK: begin
          if (tone_active && limited_length) begin
            ms_remaining_next = ms_dec;
            if (ms_dec == '0) begin
              tone_active_next    = 1'b0;
              limited_length_next = 1'b0;
            end
          end
        end
        ste_pkg::KIND_SAMPLE: begin
          if (tone_active && freq_nonzero) begin
            s1_level_next = ste_pkg::LEVEL_IN_W'(rom_mag) * ste_pkg::LEVEL_IN_W'(volume);
            s1_neg_next   = rom_neg;
            phase_next    = phase + tone_inc;
          end else begin
            phase_next = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume         <= ste_pkg::VOLUME_RESET;
      phase          <= '0;
      tone_inc       <= '0;
      ms_remaining   <= '0;
      tone_active    <= 1'b0;
      limited_length <= 1'b0;
      freq_nonzero   <= 1'b0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        volume <= cfg_wdata;
      end
      phase          <= phase_next;
      tone_inc       <= tone_inc_next;
      ms_remaining   <= ms_remaining_next;
      tone_active    <= tone_active_next;
      limited_length <= limited_length_next;
      freq_nonzero   <= freq_nonzero_next;
      if (s1_free) begin
        s1_valid <= pop && (q_kind == ste_pkg::KIND_SAMPLE);
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  assign level_prod = ste_pkg::LEVEL_PROD_W'(s1_level)
                    * ste_pkg::LEVEL_PROD_W'(ste_pkg::LEVEL_MUL);
  assign level_mag  = {1'b0, level_prod[ste_pkg::LEVEL_SHIFT +: ste_pkg::MAG_W]};

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_level   <= s1_level_next;
      s1_neg     <= s1_neg_next;
      s1_tone_on <= tone_active;
    end
    if (out_free) begin
      out_sample  <= s1_neg ? -level_mag : level_mag;
      out_tone_on <= s1_tone_on;
    end
  end

  assign result.valid   = out_valid;
  assign result.sample  = out_sample;
  assign result.tone_on = out_tone_on;

endmodule

>>> src/ste_checker.sv
// Port-level checks of the sine tone generator, bound to the top level.
// Depends on ste_pkg and on the ports of sine_tone_generator.
module ste_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                cmd_valid,
  input logic                                cmd_ready,
  input logic [1:0]                          cmd_kind,
  input logic                                result_valid,
  input logic                                result_ready,
  input logic signed [ste_pkg::SAMPLE_W-1:0] result_sample,
  input logic                                result_tone_on
);

  logic [3:0] pending;
  logic       sample_in;
  logic       sample_out;

  assign sample_in  = cmd_valid && cmd_ready && (cmd_kind == ste_pkg::KIND_SAMPLE);
  assign sample_out = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 4'(sample_in) - 4'(sample_out);
    end
  end

  a_held_request: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(result_sample) && $stable(result_tone_on))
    else $error("result request changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 4'd0)
    else $error("result request without an outstanding sample request");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'd6)
    else $error("more sample requests in flight than the block can hold");

  a_silent_off: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_tone_on |-> result_sample == '0)
    else $error("nonzero sample while no tone is on");

endmodule

bind sine_tone_generator ste_checker u_ste_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .cmd_kind       (cmd.kind),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .result_sample  (result.sample),
  .result_tone_on (result.tone_on)
);

>>> tb/sine_tone_generator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for sine_tone_generator: directed and random requests,
// predicted sample by sample against an independent phase-accumulator model.
// Depends on ste_pkg, ste_if and the sine_tone_generator RTL.
module sine_tone_generator_test;

  typedef struct packed {
    logic signed [ste_pkg::SAMPLE_W-1:0] sample;
    logic                                tone_on;
  } tone_sample_t;

  localparam int unsigned     TONE_RATE_HZ     = 16000;
  localparam logic [63:0]     QUARTER_TURN_Q60 = 64'h1921FB54442D1847;
  localparam longint unsigned FULL_SCALE_NUM   = 24000;
  localparam longint unsigned FULL_SCALE_DEN   = 255 * 32768;
  localparam int              SETTLE_CYCLES    = 8;
  localparam int              RANDOM_PHASES    = 10;
  localparam int              PHASE_REQUESTS   = 100;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [ste_pkg::VOLUME_W-1:0] cfg_wdata;

  ste_cmd_if cmd_ch ();
  ste_smp_if smp_ch ();

  sine_tone_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (smp_ch)
  );

  logic signed [15:0] sine_table [256];
  logic [31:0]        phase_acc;
  logic [31:0]        tone_step;
  logic [31:0]        ms_left;
  logic               tone_active;
  logic               limited;
  logic               freq_nonzero;
  logic [7:0]         volume_now;

  tone_sample_t pending_samples [$];

  int  requests_sent;
  int  effective_requests;
  int  samples_checked;
  int  mismatches;
  int  volume_writes;
  int  sink_hold;
  int  sink_gap;
  bit  idle_on;

  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Timed out with %0d samples still expected.", pending_samples.size());
    $display("sine_tone_generator_test NOT OK");
    $finish;
  end

  function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'h0, a} * {64'h0, b};
    return p[123:60];
  endfunction

  function automatic logic [63:0] q60_sin(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    x2   = q60_mul(x, x);
    term = x;
    acc  = x;
    for (int k = 1; k <= 13; k++) begin
      term = q60_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    return acc;
  endfunction

  task automatic fill_sine_table();
    logic [63:0]  quad;
    logic [63:0]  rem;
    logic [127:0] angle;
    logic [63:0]  mag;
    for (int i = 0; i < 256; i++) begin
      quad = 64'(i / 64);
      rem  = 64'((4 * i) % 256);
      if (quad[0]) begin
        rem = 64'd256 - rem;
      end
      angle = ({64'h0, QUARTER_TURN_Q60} * {64'h0, rem}) >> 8;
      mag   = (q60_sin(angle[63:0]) + (64'd1 << 44)) >> 45;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      sine_table[i] = (quad >= 64'd2) ? -$signed(mag[15:0]) : $signed(mag[15:0]);
    end
  endtask

  task automatic advance_tone(ste_pkg::kind_t k, logic [ste_pkg::FREQ_W-1:0] f,
                              logic [ste_pkg::DUR_W-1:0] d);
    logic [63:0]        wide;
    logic signed [15:0] entry;
    longint unsigned    mag;
    tone_sample_t       out;
    case (k)
      ste_pkg::KIND_START: begin
        wide         = ({48'h0, f} << 32) / 64'(TONE_RATE_HZ);
        tone_step    = wide[31:0];
        freq_nonzero = (f != 0);
        ms_left      = d;
        limited      = (d != 0);
        tone_active  = 1'b1;
      end
      ste_pkg::KIND_STOP: begin
        tone_active = 1'b0;
      end
      ste_pkg::KIND_MS_TICK: begin
        if (tone_active && limited) begin
          if (ms_left > 0) begin
            ms_left = ms_left - 1;
          end
          if (ms_left == 0) begin
            tone_active = 1'b0;
            limited     = 1'b0;
          end
        end
      end
      default: begin
        out.sample  = '0;
        out.tone_on = tone_active;
        if (tone_active && freq_nonzero) begin
          entry = sine_table[phase_acc[31:24]];
          mag   = longint'(entry < 0 ? -entry : entry);
          mag   = mag * volume_now * FULL_SCALE_NUM / FULL_SCALE_DEN;
          out.sample = (entry < 0) ? -$signed(mag[15:0]) : $signed(mag[15:0]);
          phase_acc  = phase_acc + tone_step;
        end else begin
          phase_acc = '0;
        end
        pending_samples.push_back(out);
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (!idle_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  task automatic send_request(ste_pkg::kind_t k, logic [ste_pkg::FREQ_W-1:0] f,
                              logic [ste_pkg::DUR_W-1:0] d);
    int   gap;
    logic effective;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.kind        <= k;
    cmd_ch.frequency   <= f;
    cmd_ch.duration_ms <= d;
    do begin
      @(posedge clk);
    end while (!cmd_ch.ready);
    effective = (k == ste_pkg::KIND_SAMPLE) || (k == ste_pkg::KIND_START) ||
                (k == ste_pkg::KIND_STOP && tone_active) ||
                (k == ste_pkg::KIND_MS_TICK && tone_active && limited);
    if (effective) begin
      effective_requests++;
    end
    requests_sent++;
    advance_tone(k, f, d);
  endtask

  task automatic wait_idle();
    cmd_ch.valid <= 1'b0;
    while (pending_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_volume(logic [ste_pkg::VOLUME_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    volume_now = v;
    volume_writes++;
  endtask

  // Sink side: random stalls, plus a long hold-off when a test asks for one.
  initial begin
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        smp_ch.ready <= 1'b0;
        sink_hold--;
      end else if (sink_gap > 0) begin
        smp_ch.ready <= 1'b0;
        sink_gap--;
      end else begin
        smp_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          sink_gap = pick_gap();
        end
      end
    end
  end

  initial begin
    tone_sample_t want;
    forever begin
      @(posedge clk);
      if (!rst && smp_ch.valid && smp_ch.ready) begin
        if (pending_samples.size() == 0) begin
          mismatches++;
          if (mismatches <= 50) begin
            $display("%0t: unexpected sample %0d tone_on %0b", $time, smp_ch.sample,
                     smp_ch.tone_on);
          end
        end else begin
          want = pending_samples.pop_front();
          samples_checked++;
          if (smp_ch.sample !== want.sample) begin
            mismatches++;
            if (mismatches <= 50) begin
              $display("%0t: sample expected %0d actual %0d", $time, want.sample,
                       smp_ch.sample);
            end
          end
          if (smp_ch.tone_on !== want.tone_on) begin
            mismatches++;
            if (mismatches <= 50) begin
              $display("%0t: tone_on expected %0b actual %0b", $time, want.tone_on,
                       smp_ch.tone_on);
            end
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_request(ste_pkg::KIND_SAMPLE, 16'd0, 32'd0);
    send_request(ste_pkg::KIND_START, 16'd4000, 32'd0);
    repeat (5) send_request(ste_pkg::KIND_SAMPLE, 16'd0, 32'd0);
    send_request(ste_pkg::KIND_START, 16'hFFFF, 32'hFFFF_FFFF);
    repeat (2) send_request(ste_pkg::KIND_SAMPLE, 16'd0, 32'd0);
    send_request(ste_pkg::KIND_START, 16'd0, 32'd0);
    send_request(ste_pkg::KIND_SAMPLE, 16'd0, 32'd0);
    send_request(ste_pkg::KIND_START, 16'd16000, 32'd2);
    send_request(ste_pkg::KIND_SAMPLE, 16'd0, 32'd0);
    send_request(ste_pkg::KIND_MS_TICK, 16'd0, 32'd0);
    send_request(ste_pkg::KIND_SAMPLE, 16'd0, 32'd0);
    send_request(ste_pkg::KIND_MS_TICK, 16'd0, 32'd0);
    send_request(ste_pkg::KIND_SAMPLE, 16'd0, 32'd0);
    send_request(ste_pkg::KIND_MS_TICK, 16'd0, 32'd0);
    send_request(ste_pkg::KIND_START, 16'd1, 32'd0);
    send_request(ste_pkg::KIND_SAMPLE, 16'd0, 32'd0);
    send_request(ste_pkg::KIND_MS_TICK, 16'd0, 32'd0);
    send_request(ste_pkg::KIND_STOP, 16'd0, 32'd0);
    send_request(ste_pkg::KIND_SAMPLE, 16'd0, 32'd0);
    send_request(ste_pkg::KIND_STOP, 16'd0, 32'd0);
    wait_idle();
  endtask

  task automatic test_volume_levels();
    set_volume(8'd255);
    send_request(ste_pkg::KIND_START, 16'd4000, 32'd0);
    repeat (8) send_request(ste_pkg::KIND_SAMPLE, 16'd0, 32'd0);
    set_volume(8'd0);
    repeat (4) send_request(ste_pkg::KIND_SAMPLE, 16'd0, 32'd0);
    set_volume(8'd1);
    repeat (4) send_request(ste_pkg::KIND_SAMPLE, 16'd0, 32'd0);
    wait_idle();
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    send_request(ste_pkg::KIND_START, 16'd1234, 32'd0);
    sink_hold = 80;
    repeat (30) send_request(ste_pkg::KIND_SAMPLE, 16'd0, 32'd0);
    wait_idle();
    idle_on = 1'b1;
  endtask

  function automatic logic [ste_pkg::FREQ_W-1:0] random_frequency();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return ste_pkg::FREQ_W'($urandom_range(16000, 65535));
    end else if (r < 6) begin
      return ste_pkg::FREQ_W'($urandom_range(1, 4000));
    end
    return ste_pkg::FREQ_W'($urandom);
  endfunction

  function automatic logic [ste_pkg::DUR_W-1:0] random_duration();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end else if (r == 2) begin
      return $urandom;
    end
    return $urandom_range(1, 12);
  endfunction

  task automatic play_random_tone();
    int n;
    int r;
    n = $urandom_range(3, 20);
    send_request(ste_pkg::KIND_START, random_frequency(), random_duration());
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_request(ste_pkg::KIND_SAMPLE, ste_pkg::FREQ_W'($urandom), $urandom);
      end else if (r < 95) begin
        send_request(ste_pkg::KIND_MS_TICK, ste_pkg::FREQ_W'($urandom), $urandom);
      end else begin
        send_request(ste_pkg::KIND_STOP, ste_pkg::FREQ_W'($urandom), $urandom);
      end
    end
  endtask

  task automatic test_random_tones();
    int goal;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       set_volume(8'd255);
        1:       set_volume(8'd0);
        2:       set_volume(ste_pkg::VOLUME_RESET);
        default: set_volume(ste_pkg::VOLUME_W'($urandom_range(0, 255)));
      endcase
      idle_on = (p % 3 != 2);
      goal    = effective_requests + PHASE_REQUESTS;
      while (effective_requests < goal) begin
        if ($urandom_range(0, 99) < 85) begin
          play_random_tone();
        end else begin
          send_request(ste_pkg::kind_t'($urandom_range(0, 3)), random_frequency(),
                       random_duration());
        end
      end
    end
    idle_on = 1'b1;
    wait_idle();
  endtask

  initial begin
    int waited;
    clk                = 1'b0;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.kind        = ste_pkg::KIND_SAMPLE;
    cmd_ch.frequency   = '0;
    cmd_ch.duration_ms = '0;
    smp_ch.ready       = 1'b0;
    phase_acc          = '0;
    tone_step          = '0;
    ms_left            = '0;
    tone_active        = 1'b0;
    limited            = 1'b0;
    freq_nonzero       = 1'b0;
    volume_now         = ste_pkg::VOLUME_RESET;
    idle_on            = 1'b1;
    sink_hold          = 0;
    sink_gap           = 0;
    fill_sine_table();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_volume_levels();
    test_backpressure();
    test_random_tones();

    cmd_ch.valid <= 1'b0;
    waited = 0;
    while (pending_samples.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_samples.size() != 0) begin
      mismatches += pending_samples.size();
      $display("%0t: %0d expected samples never arrived", $time, pending_samples.size());
    end
    $display("Sent %0d requests (%0d that change the tone or ask for a sample).",
             requests_sent, effective_requests);
    $display("Checked %0d samples over %0d volume settings, with sink hold-off and gaps.",
             samples_checked, volume_writes);
    if (mismatches == 0) begin
      $display("sine_tone_generator_test OK");
    end else begin
      $display("sine_tone_generator_test NOT OK");
    end
    $finish;
  end

endmodule

>>> sine_tone_generator.f
src/ste_pkg.sv
src/ste_if.sv
src/ste_front.sv
src/ste_queue.sv
src/ste_back.sv
src/sine_tone_generator.sv
src/ste_checker.sv
tb/sine_tone_generator_test.sv
